### design/assert_macros.svh
// Assertion helpers, sampled on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

### design/gbn_pkg.sv
package gbn_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_WINDOW  = 8;
  localparam int WIN_W       = 4;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);
  localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(MAX_WINDOW);

  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] handle;
    logic [11:0] length;
  } rec_t;

endpackage

### design/go_back_n_sender_top.sv
// A send reads each frame that may enter the window (FILL_RD) and emits it (FILL_TX), one frame at a time.
// An ack searches the outstanding entries (ACK_RD, ACK_CMP); on a match it fills the window the same way.
// A timeout resends every outstanding frame (TO_RD, TO_TX); a drop is answered from idle, a no-op does nothing.
// One queue-memory read port sets the pace; a new command is accepted only while idle (busy low).
// Reset (rst, synchronous): queue empty, nothing outstanding, window_limit 4, idle.
// Results cannot be stalled by the receiver.
`include "assert_macros.svh"

module go_back_n_sender_top import gbn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              window_limit_we,
  input  logic [WIN_W-1:0]  window_limit,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode,
  input  logic [31:0]       seq_no,
  input  logic [15:0]       frame_handle,
  input  logic [11:0]       frame_length,
  output logic              strobe,
  output logic              status,
  output logic [31:0]       tx_seq,
  output logic [15:0]       tx_handle,
  output logic [11:0]       tx_length,
  output logic              last
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FILL_RD = 3'd1;
  localparam logic [2:0] ST_FILL_TX = 3'd2;
  localparam logic [2:0] ST_ACK_RD  = 3'd3;
  localparam logic [2:0] ST_ACK_CMP = 3'd4;
  localparam logic [2:0] ST_TO_RD   = 3'd5;
  localparam logic [2:0] ST_TO_TX   = 3'd6;

  logic [2:0]          state;
  logic [WIN_W-1:0]    win_reg;
  logic [WIN_W-1:0]    win_eff;
  logic [QADDR_W-1:0]  queue_head;
  logic [QCOUNT_W-1:0] queue_count;
  logic [WIN_W-1:0]    outstanding;
  logic [WIN_W-1:0]    idx;
  logic [31:0]         op_seq;

  rec_t                mem [QUEUE_DEPTH];
  rec_t                rdata;
  logic [QADDR_W-1:0]  raddr;
  logic [QADDR_W-1:0]  waddr;
  logic                wr_en;
  logic                accept;
  logic                full;
  logic                fill_more;
  logic [WIN_W-1:0]    out_inc;
  logic [WIN_W-1:0]    idx_inc;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (queue_count >= QCOUNT_W'(QUEUE_DEPTH));
  assign waddr   = queue_head + queue_count[QADDR_W-1:0];
  assign wr_en   = accept && (opcode == OP_SEND) && !full;
  assign out_inc = outstanding + WIN_W'(1);
  assign idx_inc = idx + WIN_W'(1);

  always_comb begin
    if (win_reg == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_reg > WINDOW_MAX) begin
      win_eff = WINDOW_MAX;
    end else begin
      win_eff = win_reg;
    end
  end

  always_comb begin
    if (state == ST_FILL_RD) begin
      raddr = queue_head + QADDR_W'(outstanding);
    end else begin
      raddr = queue_head + QADDR_W'(idx);
    end
  end

  // more frames may enter the window after the one being sent
  assign fill_more = (out_inc < win_eff) && (QCOUNT_W'(out_inc) < queue_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= '{seq: seq_no, handle: frame_handle, length: frame_length};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= WINDOW_RESET;
    end else if (window_limit_we) begin
      win_reg <= window_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      queue_head  <= '0;
      queue_count <= '0;
      outstanding <= '0;
      idx         <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= (accept && (opcode == OP_SEND) && full) ||
                (state == ST_FILL_TX) || (state == ST_TO_TX);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_seq <= seq_no;
            idx    <= '0;
            unique case (opcode)
              OP_SEND: begin
                if (full) begin
                  status    <= 1'b1;
                  tx_seq    <= '0;
                  tx_handle <= '0;
                  tx_length <= '0;
                  last      <= 1'b1;
                end else begin
                  queue_count <= queue_count + QCOUNT_W'(1);
                  state       <= ST_FILL_RD;
                end
              end
              OP_ACK: begin
                state <= ST_ACK_RD;
              end
              OP_TIMEOUT: begin
                state <= ST_TO_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL_RD: begin
          if ((outstanding < win_eff) && (QCOUNT_W'(outstanding) < queue_count)) begin
            state <= ST_FILL_TX;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FILL_TX: begin
          status      <= 1'b0;
          tx_seq      <= rdata.seq;
          tx_handle   <= rdata.handle;
          tx_length   <= rdata.length;
          last        <= !fill_more;
          outstanding <= out_inc;
          state       <= fill_more ? ST_FILL_RD : ST_IDLE;
        end
        ST_ACK_RD: begin
          state <= (idx < outstanding) ? ST_ACK_CMP : ST_IDLE;
        end
        ST_ACK_CMP: begin
          if (rdata.seq == op_seq) begin
            queue_head  <= queue_head + QADDR_W'(idx_inc);
            queue_count <= queue_count - QCOUNT_W'(idx_inc);
            outstanding <= outstanding - idx_inc;
            state       <= ST_FILL_RD;
          end else begin
            idx   <= idx_inc;
            state <= ST_ACK_RD;
          end
        end
        ST_TO_RD: begin
          state <= (idx < outstanding) ? ST_TO_TX : ST_IDLE;
        end
        ST_TO_TX: begin
          status    <= 1'b0;
          tx_seq    <= rdata.seq;
          tx_handle <= rdata.handle;
          tx_length <= rdata.length;
          last      <= (idx_inc == outstanding);
          idx       <= idx_inc;
          state     <= (idx_inc == outstanding) ? ST_IDLE : ST_TO_RD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_out_le_count, QCOUNT_W'(outstanding) <= queue_count)
  `ASSERT_CLK(a_count_le_depth, queue_count <= QCOUNT_W'(QUEUE_DEPTH))
  `ASSERT_CLK(a_out_le_max, outstanding <= WINDOW_MAX)
  `ASSERT_CLK(a_drop_is_last, strobe && status |-> last)
  `ASSERT_CLK(a_tx_from_walk,
      strobe && !status |-> $past(state == ST_FILL_TX || state == ST_TO_TX))

endmodule
